@@ hdl/itmag_pkg.sv @@
// ----------------------------------------------------------------------------
// itmag_pkg
// Shared types, layout constants and command/status bundles for the
// integrity-tree metadata address generator.
// ----------------------------------------------------------------------------
package itmag_pkg;

	// Address and region geometry (sizes are powers of two)
	localparam int ADDR_BITS   = 48;
	localparam int BASE_BITS   = 47;
	localparam int BLOCK_BYTES = 64;
	localparam int MAC_BYTES   = 8;
	localparam int PAGE_BYTES  = 4096;
	localparam int TREE_ARITY  = 8;
	localparam int MAX_LEVELS  = 16;

	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int MAC_SHIFT   = $clog2(MAC_BYTES);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int ARITY_SHIFT = $clog2(TREE_ARITY);
	localparam int LVL_BITS    = $clog2(MAX_LEVELS);
	// pages in the region, and block index within a level
	localparam int BLK_BITS    = ADDR_BITS - PAGE_SHIFT;

	localparam int KIND_BITS    = 2;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [ADDR_BITS-1:0]    addr_t;
	typedef logic [BASE_BITS-1:0]    base_t;
	typedef logic [LVL_BITS-1:0]     lvl_t;
	typedef logic [BLK_BITS-1:0]     blk_t;
	typedef logic [KIND_BITS-1:0]    kind_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam addr_t DATA_BYTES_RST = addr_t'(64'd1073741824);

	// Configuration register indexes
	localparam cfg_idx_t CFG_DATA_BASE  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_DATA_BYTES = cfg_idx_t'(1);

	// Metadata kinds
	localparam kind_t KIND_MAC     = kind_t'(0);
	localparam kind_t KIND_COUNTER = kind_t'(1);
	localparam kind_t KIND_TREE    = kind_t'(2);

	// Controller to datapath
	typedef struct packed {
		logic load_req;   // capture request, range check, start level sizing
		logic size_step;  // one ceiling-divide step of the level count
		logic base_init;  // load counter-level base into the walk register
		logic out_load;   // write one result into the output register
		logic out_walk;   // result is a counter/tree node, else MAC or flag
		logic walk_step;  // advance walk one level toward the root
	} itmag_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic size_done;  // level count settled
		logic oor;        // request lies outside the data region
		logic walk_last;  // walk sits at the root
		logic out_free;   // output register can take a result this cycle
	} itmag_stat_t;

endpackage

@@ hdl/integrity_tree_metadata_addr_gen.sv @@
// ----------------------------------------------------------------------------
// integrity_tree_metadata_addr_gen
// For each data address, emits the MAC block, the counter block and every
// integrity-tree ancestor up to the root, with the final beat marked.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, req_addr) takes one data address.
//   Output channel (out_valid/out_ready) returns one metadata address per
//   beat: MAC block, counter block, then tree nodes toward the root, with
//   last on the root. An address outside the region gives one beat with
//   out_of_range and last set.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   data_base (index 0) and data_bytes (index 1); other indexes are ignored.
//   cfg_ready is always high; write only while the block is idle.
// Timing: with L the counter level number (tree depth, at most 15), a
//   request is accepted, then the levels are sized (one ceiling divide per
//   cycle), then L+2 result beats follow at one per cycle unless out_ready
//   is held low. The next request is taken once the last beat is in the
//   output register.
// Stalls: a held out_ready freezes the walk; the pending beat stays put.
// Reset: clears the sequencer and output valid, restores data_base = 0 and
//   data_bytes = 1 GiB.
// ----------------------------------------------------------------------------
module integrity_tree_metadata_addr_gen (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  itmag_pkg::cfg_idx_t cfg_index,
	input  itmag_pkg::addr_t    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  itmag_pkg::addr_t    req_addr,
	output logic                out_valid,
	input  logic                out_ready,
	output itmag_pkg::addr_t    meta_addr,
	output itmag_pkg::kind_t    meta_kind,
	output itmag_pkg::lvl_t     tree_level,
	output logic                out_of_range,
	output logic                last
);
	import itmag_pkg::*;

	itmag_cmd_t  cmd;
	itmag_stat_t stat;

	// Register writes are always accepted
	assign cfg_ready = 1'b1;

	// Sequencer
	itmag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Address datapath
	itmag_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_addr     (req_addr),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.meta_addr    (meta_addr),
		.meta_kind    (meta_kind),
		.tree_level   (tree_level),
		.out_of_range (out_of_range),
		.last         (last)
	);

endmodule

@@ hdl/itmag_ctrl.sv @@
// ----------------------------------------------------------------------------
// itmag_ctrl
// Sequencer: takes one request, sizes the tree, emits the MAC result and then
// walks counter level to root if in range; one result per unstalled cycle.
// ----------------------------------------------------------------------------
module itmag_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  itmag_pkg::itmag_stat_t stat,
	output itmag_pkg::itmag_cmd_t  cmd
);
	import itmag_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SIZE = 4'b0010,
		ST_MAC  = 4'b0100,
		ST_WALK = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_SIZE;
				end
			end
			ST_SIZE: begin
				cmd.base_init = 1'b1;
				if (stat.size_done) begin
					state_d = ST_MAC;
				end else begin
					cmd.size_step = 1'b1;
				end
			end
			ST_MAC: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = stat.oor ? ST_IDLE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_walk  = 1'b1;
					cmd.walk_step = 1'b1;
					if (stat.walk_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/itmag_dpath.sv @@
// ----------------------------------------------------------------------------
// itmag_dpath
// Configuration registers, region check, level sizing, walk registers and the
// output register.
// ----------------------------------------------------------------------------
module itmag_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  itmag_pkg::cfg_idx_t      cfg_index,
	input  itmag_pkg::addr_t         cfg_data,
	input  itmag_pkg::addr_t         req_addr,
	input  itmag_pkg::itmag_cmd_t    cmd,
	output itmag_pkg::itmag_stat_t   stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output itmag_pkg::addr_t         meta_addr,
	output itmag_pkg::kind_t         meta_kind,
	output itmag_pkg::lvl_t          tree_level,
	output logic                     out_of_range,
	output logic                     last
);
	import itmag_pkg::*;

	base_t data_base_q;
	addr_t data_bytes_q;

	addr_t off_q;
	logic  oor_q;
	addr_t mac_area_q;
	blk_t  blk_q;
	lvl_t  cnt_q;
	addr_t base_q;
	blk_t  idx_q;
	lvl_t  lvl_q;

	logic  out_valid_q;
	addr_t addr_q;
	kind_t kind_q;
	lvl_t  level_q;
	logic  oor_out_q;
	logic  last_q;

	addr_t req_off;
	logic  req_oor;
	blk_t  blocks0;
	logic [BLK_BITS:0] blk_sum;
	blk_t  blk_next;
	addr_t base0;
	addr_t mac_addr;
	addr_t walk_addr;
	addr_t level_bytes;
	logic  out_free;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q  <= '0;
			data_bytes_q <= DATA_BYTES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DATA_BASE:  data_base_q  <= cfg_data[BASE_BITS-1:0];
				CFG_DATA_BYTES: data_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Region check and offset
	assign req_off = req_addr - addr_t'(data_base_q);
	assign req_oor = (req_addr < addr_t'(data_base_q)) || (req_off >= data_bytes_q);

	// Level sizing: ceiling divide by the arity
	assign blocks0  = blk_t'(data_bytes_q >> PAGE_SHIFT);
	assign blk_sum  = {1'b0, blk_q} + (BLK_BITS+1)'(TREE_ARITY - 1);
	assign blk_next = blk_t'(blk_sum >> ARITY_SHIFT);

	// Counter level starts after the MAC area
	assign base0 = mac_area_q + addr_t'((data_bytes_q >> BLOCK_SHIFT) << MAC_SHIFT);

	// MAC block address, aligned down to a block
	assign mac_addr = (mac_area_q + addr_t'((off_q >> BLOCK_SHIFT) << MAC_SHIFT))
		& ~addr_t'(BLOCK_BYTES - 1);

	// Node address in the current level, and the span of that level
	assign walk_addr   = base_q + addr_t'({idx_q, {BLOCK_SHIFT{1'b0}}});
	assign level_bytes = addr_t'({blk_q, {BLOCK_SHIFT{1'b0}}});

	// Request, sizing and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			off_q      <= req_off;
			oor_q      <= req_oor;
			mac_area_q <= addr_t'(data_base_q) + data_bytes_q;
			blk_q      <= blocks0;
			cnt_q      <= '0;
		end else if (cmd.size_step) begin
			blk_q <= blk_next;
			cnt_q <= cnt_q + lvl_t'(1);
		end else if (cmd.out_load && !cmd.out_walk) begin
			blk_q <= blocks0;
			idx_q <= blk_t'(off_q >> PAGE_SHIFT);
			lvl_q <= cnt_q;
		end else if (cmd.walk_step) begin
			base_q <= base_q + level_bytes;
			blk_q  <= blk_next;
			idx_q  <= idx_q >> ARITY_SHIFT;
			lvl_q  <= lvl_q - lvl_t'(1);
		end
		if (cmd.base_init) begin
			base_q <= base0;
		end
	end

	// Output register: refill when empty or being drained
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_walk) begin
				addr_q    <= walk_addr;
				kind_q    <= (lvl_q == cnt_q) ? KIND_COUNTER : KIND_TREE;
				level_q   <= lvl_q;
				oor_out_q <= 1'b0;
				last_q    <= (lvl_q == '0);
			end else begin
				addr_q    <= oor_q ? '0 : mac_addr;
				kind_q    <= KIND_MAC;
				level_q   <= '0;
				oor_out_q <= oor_q;
				last_q    <= oor_q;
			end
		end
	end

	// Status toward the controller
	assign stat.size_done = (cnt_q == lvl_t'(MAX_LEVELS - 1)) || (blk_q <= blk_t'(1));
	assign stat.oor       = oor_q;
	assign stat.walk_last = (lvl_q == '0);
	assign stat.out_free  = out_free;

	assign out_valid    = out_valid_q;
	assign meta_addr    = addr_q;
	assign meta_kind    = kind_q;
	assign tree_level   = level_q;
	assign out_of_range = oor_out_q;
	assign last         = last_q;

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over a pending beat");

	// A completed walk ends at the root with a counter or tree node
	a_last_root: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q && !oor_out_q) |->
			(level_q == '0) && (kind_q != KIND_MAC))
		else $error("last beat not at the root");

	// A flagged request yields a single cleared MAC beat
	a_oor_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oor_out_q) |-> last_q && (addr_q == '0) && (kind_q == KIND_MAC))
		else $error("out-of-range beat malformed");

	// The walk never climbs above the counter level
	a_walk_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (lvl_q <= cnt_q))
		else $error("walk level above counter level");

endmodule
